// ===== rtl/lifo_stack_with_reverse_defines.svh =====
// Assertion macros for the LIFO stack block.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef LIFO_STACK_WITH_REVERSE_DEFINES_SVH
`define LIFO_STACK_WITH_REVERSE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on i_clk, off during reset
`define LSWR_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LSWR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LSWR_ASSERT(lbl, ante, cons, msg)
`define LSWR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/lswr_pkg.sv =====
// Shared constants and types for the LIFO stack block.
// No dependencies; imported by the stack top and the swap walk, not by lswr_ram.
package lswr_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 128;
    localparam int CNT_OUT_W       = 8;
    localparam int CMD_W           = 2;
    localparam int ST_W            = 2;
    localparam int OUT_DATA_W      = DATA_W + CNT_OUT_W;
    localparam int OUT_USER_W      = ST_W + 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // swap walk status toward the main sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_walk_stat;

endpackage

// ===== rtl/lifo_stack_with_reverse.sv =====
// LIFO stack of signed 32-bit words with in-place reverse. Usage:
//   Slave stream takes one command word: tuser = cmd (0 push, 1 pop, 2 reverse,
//   3 no-op), tdata = push value. Master stream returns one result word per
//   command: tdata = pop value and item count, tuser = status and flags.
//   Commands are handled one at a time; tready is low while one is in work
//   or while the result register ahead of the output is occupied.
//   Work from accept to result register:
//     push, no-op, reverse of 0 or 1 entries, refused push/pop: direct load
//     pop: registered RAM read, then result load
//     reverse of n entries: floor(n/2) swap steps; each swap step takes two reads
//     and two writes on the single-write, single-read RAM port.
//   The result then moves into the output register once that is free. A finished
//   result waits in the output register while the next command is taken, so
//   a stalled receiver holds up input only once the result register fills.
//   Reset (i_rst_n low, synchronous) empties the stack and drops any pending
//   results; RAM contents are left as they are and never read before written.
//   Output holds tdata/tuser stable while tvalid is high and tready is low.
// Depends on lswr_pkg, lswr_ram, lswr_walk and the defines header.
`include "lifo_stack_with_reverse_defines.svh"

module lifo_stack_with_reverse #(
    parameter int STACK_DEPTH = lswr_pkg::STACK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [lswr_pkg::DATA_W-1:0]     i_s_axis_tdata,  // [31:0] push_value
    input  logic [lswr_pkg::CMD_W-1:0]      i_s_axis_tuser,  // [1:0] cmd
    // result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [lswr_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // [31:0] pop_value,
                                                             // [39:32] item_count
    output logic [lswr_pkg::OUT_USER_W-1:0] o_m_axis_tuser   // [1:0] status,
                                                             // [2] is_empty, [3] is_full
);
    import lswr_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_REV  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_fill, n_fill;
    // result register, then output register
    logic [OUT_DATA_W-1:0] r_res_data, n_res_data;
    logic [OUT_USER_W-1:0] r_res_user, n_res_user;
    logic                  r_res_vld, n_res_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_out_vld, n_out_vld;

    logic                  acc;
    logic                  pop_go;
    logic                  move;
    logic                  is_full_now, is_empty_now, has_two;
    logic                  load;
    logic [DATA_W-1:0]     res_pop;
    logic [ST_W-1:0]       res_st;
    logic [CW+CNT_OUT_W-1:0] res_cnt_ext;

    // RAM port, shared between push/pop and the swap walk
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_W-1:0]     ram_wdata, ram_rdata;
    logic [CW-1:0]         fill_m1;

    // swap walk
    logic                  w_start;
    t_walk_stat            w_stat;
    logic                  w_re, w_we;
    logic [AW-1:0]         w_raddr, w_waddr;
    logic [DATA_W-1:0]     w_wdata;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_res_vld;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign move            = r_res_vld && (!r_out_vld || i_m_axis_tready);

    assign is_full_now  = (r_fill == CW'(STACK_DEPTH));
    assign is_empty_now = (r_fill == '0);
    assign has_two      = (r_fill > CW'(1));
    assign fill_m1      = r_fill - CW'(1);
    assign pop_go       = acc && (i_s_axis_tuser == CMD_POP) && !is_empty_now;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        load      = 1'b0;
        res_pop   = '0;
        res_st    = ST_OK;
        w_start   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_fill[AW-1:0];
        ram_wdata = i_s_axis_tdata;
        ram_re    = 1'b0;
        ram_raddr = fill_m1[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_s_axis_tuser)
                        CMD_PUSH: begin
                            load = 1'b1;
                            if (is_full_now) begin
                                res_st = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (is_empty_now) begin
                                load   = 1'b1;
                                res_st = ST_EMPTY;
                            end else begin
                                ram_re  = 1'b1;
                                n_fill  = fill_m1;
                                n_state = S_POP;
                            end
                        end
                        CMD_REVERSE: begin
                            if (has_two) begin
                                w_start = 1'b1;
                                n_state = S_REV;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        default: begin
                            load = 1'b1;  // unused code: report state only
                        end
                    endcase
                end
            end
            S_POP: begin
                load    = 1'b1;
                res_pop = ram_rdata;
                n_state = S_IDLE;
            end
            S_REV: begin
                if (w_stat.done) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_stat.busy) begin
            ram_we    = w_we;
            ram_waddr = w_waddr;
            ram_wdata = w_wdata;
            ram_re    = w_re;
            ram_raddr = w_raddr;
        end
    end

    // result fields reflect the count after the command
    assign res_cnt_ext = {{CNT_OUT_W{1'b0}}, n_fill};

    always_comb begin
        n_res_data = r_res_data;
        n_res_user = r_res_user;
        n_res_vld  = r_res_vld;
        if (load) begin
            n_res_data = {res_cnt_ext[CNT_OUT_W-1:0], res_pop};
            n_res_user = {(n_fill == CW'(STACK_DEPTH)), (n_fill == '0), res_st};
            n_res_vld  = 1'b1;
        end else if (move) begin
            n_res_vld  = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (move) begin
            n_out_vld = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_res_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_res_vld <= n_res_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_data <= n_res_data;
        r_res_user <= n_res_user;
        if (move) begin
            r_out_data <= r_res_data;
            r_out_user <= r_res_user;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    lswr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lswr_walk #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_fill  (r_fill),
        .o_stat  (w_stat),
        .o_re    (w_re),
        .o_raddr (w_raddr),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .i_rdata (ram_rdata)
    );

    // checks
    `LSWR_ASSERT(a_no_accept_in_walk, w_stat.busy, !o_s_axis_tready, "accept during swap walk")
    `LSWR_ASSERT(a_fill_bound, 1'b1, r_fill <= CW'(STACK_DEPTH), "fill beyond depth")
    `LSWR_ASSERT_NEXT(a_pop_reads, pop_go, r_state == S_POP && !r_res_vld, "pop skipped read")
    `LSWR_ASSERT(a_walk_only_rev, w_stat.busy, r_state == S_REV, "walk busy outside reverse")

endmodule

// ===== rtl/lswr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lswr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lswr_walk.sv =====
// Swap walk sequencer: reverses entries 0..fill-1 in place through the RAM port.
// Depends on lswr_pkg; drives the RAM only while busy.
module lswr_walk #(
    parameter int DEPTH = lswr_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = lswr_pkg::DATA_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [$clog2(DEPTH+1)-1:0] i_fill,
    output lswr_pkg::t_walk_stat       o_stat,
    output logic                       o_re,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic [WIDTH-1:0]           o_wdata,
    input  logic [WIDTH-1:0]           i_rdata
);
    import lswr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_RDLO = 3'd1;
    localparam logic [2:0] W_RDHI = 3'd2;
    localparam logic [2:0] W_WRLO = 3'd3;
    localparam logic [2:0] W_WRHI = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_lo, n_lo;
    logic [AW-1:0]    r_hi, n_hi;
    logic [WIDTH-1:0] r_tmp;
    logic [CW-1:0]    fill_m1;
    logic [AW-1:0]    lo_inc, hi_dec;
    logic             more;

    assign fill_m1 = i_fill - CW'(1);

    // the step unit: advance both ends, test whether another pair remains to swap
    assign lo_inc = r_lo + AW'(1);
    assign hi_dec = r_hi - AW'(1);
    assign more   = lo_inc < hi_dec;

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        o_re    = 1'b0;
        o_raddr = r_lo;
        o_we    = 1'b0;
        o_waddr = r_lo;
        o_wdata = i_rdata;
        o_stat  = '{busy: (r_state != W_IDLE), done: 1'b0};
        case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_lo    = '0;
                    n_hi    = fill_m1[AW-1:0];
                    n_state = W_RDLO;
                end
            end
            W_RDLO: begin
                o_re    = 1'b1;
                n_state = W_RDHI;
            end
            W_RDHI: begin
                o_re    = 1'b1;
                o_raddr = r_hi;
                n_state = W_WRLO;
            end
            W_WRLO: begin
                o_we    = 1'b1;
                n_state = W_WRHI;
            end
            W_WRHI: begin
                o_we    = 1'b1;
                o_waddr = r_hi;
                o_wdata = r_tmp;
                n_lo    = lo_inc;
                n_hi    = hi_dec;
                if (more) begin
                    n_state = W_RDLO;
                end else begin
                    n_state     = W_IDLE;
                    o_stat.done = 1'b1;
                end
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        // low-end word arrives in the cycle its high-end read is issued
        if (r_state == W_RDHI) begin
            r_tmp <= i_rdata;
        end
    end

endmodule
